### hdl/bcd_clock_with_alarm_top_macros.svh
// Assertion macros for the BCD clock with alarm.
// Used by the port checker; the includer provides aclk and aresetn.
`ifndef BCD_CLOCK_WITH_ALARM_TOP_MACROS_SVH
`define BCD_CLOCK_WITH_ALARM_TOP_MACROS_SVH

// Checked only while out of reset.
`define BCLK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define BCLK_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### hdl/bcdclk_pkg.sv
// Package for the BCD clock with alarm: item codes, tdata layout, time digit
// type and the one-second BCD increment. No dependencies.
package bcdclk_pkg;

    // Configuration
    localparam int TPS_W = 16;
    localparam logic [TPS_W-1:0] TPS_RESET = 16'd1000;

    // Stream widths
    localparam int S_DATA_W = 24;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 24;

    // Time digits occupy the low bits of both tdata words
    localparam int TIME_W    = 20;
    localparam int ST_LSB    = 13;
    localparam int SU_LSB    = 16;
    localparam int VALID_BIT = 20;
    localparam int ARMED_BIT = 21;
    localparam int EVENT_BIT = 22;

    typedef enum logic [S_USER_W-1:0] {
        MODE_TICK      = 2'd0,
        MODE_SET_TIME  = 2'd1,
        MODE_SET_ALARM = 2'd2,
        MODE_TOGGLE    = 2'd3
    } mode_t;

    // Declared from the top bit down so hour_tens sits at bit 0
    typedef struct packed {
        logic [3:0] second_units;
        logic [2:0] second_tens;
        logic [3:0] minute_units;
        logic [2:0] minute_tens;
        logic [3:0] hour_units;
        logic [1:0] hour_tens;
    } clock_time_t;

    // One-second increment with BCD carries; hours wrap from 23 to 00.
    // Out-of-range digits wrap at the threshold compares.
    function automatic clock_time_t advance_second(input clock_time_t t);
        clock_time_t n;
        n = t;
        if (t.second_units < 4'd9) begin
            n.second_units = t.second_units + 4'd1;
        end else begin
            n.second_units = '0;
            if (t.second_tens < 3'd5) begin
                n.second_tens = t.second_tens + 3'd1;
            end else begin
                n.second_tens = '0;
                if (t.minute_units < 4'd9) begin
                    n.minute_units = t.minute_units + 4'd1;
                end else begin
                    n.minute_units = '0;
                    if (t.minute_tens < 3'd5) begin
                        n.minute_tens = t.minute_tens + 3'd1;
                    end else begin
                        n.minute_tens = '0;
                        if (t.hour_tens >= 2'd2 && t.hour_units >= 4'd3) begin
                            n.hour_tens  = '0;
                            n.hour_units = '0;
                        end else if (t.hour_units >= 4'd9) begin
                            n.hour_units = '0;
                            n.hour_tens  = t.hour_tens + 2'd1;
                        end else begin
                            n.hour_units = t.hour_units + 4'd1;
                        end
                    end
                end
            end
        end
        return n;
    endfunction

endpackage

### hdl/bcd_clock_with_alarm_top.sv
// 24-hour BCD clock with alarm, top level.
// Depends on bcdclk_pkg.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tuser mode, s_tdata set digits
//  m_      | out | m_tvalid/m_tready  | m_tdata time digits and flags
//  cfg_    | in  | cfg_wr_en          | cfg_wr_data ticks per second
//
// The carry chain of the BCD increment and the alarm compare sit between the
// state registers and the result register.
// One item per cycle is accepted while the result register is empty or
// being drained in the same cycle; a stalled m_ side holds the result.
// Reset (aresetn low, synchronous) clears time, alarm, prescaler and flags
// and sets ticks per second to 1000.
module bcd_clock_with_alarm_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [bcdclk_pkg::TPS_W-1:0]       cfg_wr_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [1:0] hour_tens, [5:2] hour_units, [8:6] minute_tens, [12:9] minute_units,
    // [15:13] second_tens, [19:16] second_units, [23:20] zero
    input  logic [bcdclk_pkg::S_DATA_W-1:0]    s_tdata,
    // [1:0] mode
    input  logic [bcdclk_pkg::S_USER_W-1:0]    s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [1:0] now_hour_tens, [5:2] now_hour_units, [8:6] now_minute_tens,
    // [12:9] now_minute_units, [15:13] now_second_tens,
    // [19:16] now_second_units, [20] time_valid, [21] alarm_enabled,
    // [22] alarm_event, [23] zero
    output logic [bcdclk_pkg::M_DATA_W-1:0]    m_tdata
);

    logic [bcdclk_pkg::TPS_W-1:0]    tps_reg;
    logic [bcdclk_pkg::TPS_W-1:0]    tick_count_reg, tick_count_next;
    bcdclk_pkg::clock_time_t         time_reg, time_next;
    bcdclk_pkg::clock_time_t         alarm_reg, alarm_next;
    logic                            valid_reg, valid_next;
    logic                            armed_reg, armed_next;
    logic                            m_tvalid_reg;
    logic [bcdclk_pkg::M_DATA_W-1:0] m_tdata_reg;

    logic                            accept;
    logic                            event_hit;
    logic [bcdclk_pkg::TPS_W:0]      tick_plus;
    bcdclk_pkg::mode_t               mode;
    bcdclk_pkg::clock_time_t         in_time;
    bcdclk_pkg::clock_time_t         adv_time;

    // Handshake: take an item when the result register is free or draining
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign mode      = bcdclk_pkg::mode_t'(s_tuser);
    assign in_time   = bcdclk_pkg::clock_time_t'(s_tdata[bcdclk_pkg::TIME_W-1:0]);
    assign adv_time  = bcdclk_pkg::advance_second(time_reg);
    assign tick_plus = {1'b0, tick_count_reg} + {{bcdclk_pkg::TPS_W{1'b0}}, 1'b1};

    // Next state for the item at the input
    always_comb begin
        tick_count_next = tick_count_reg;
        time_next       = time_reg;
        alarm_next      = alarm_reg;
        valid_next      = valid_reg;
        armed_next      = armed_reg;
        event_hit       = 1'b0;
        unique case (mode)
            bcdclk_pkg::MODE_TICK: begin
                // a zero setting behaves as one: every tick ends a second
                if (tick_plus >= {1'b0, tps_reg}) begin
                    tick_count_next = '0;
                    time_next       = adv_time;
                    event_hit       = armed_reg
                                      && adv_time.second_tens == 3'd0
                                      && adv_time.second_units == 4'd0
                                      && alarm_reg == adv_time;
                end else begin
                    tick_count_next = tick_plus[bcdclk_pkg::TPS_W-1:0];
                end
            end
            bcdclk_pkg::MODE_SET_TIME: begin
                time_next  = in_time;
                valid_next = 1'b1;
            end
            bcdclk_pkg::MODE_SET_ALARM: begin
                alarm_next = in_time;
                armed_next = 1'b1;
            end
            bcdclk_pkg::MODE_TOGGLE: begin
                armed_next = !armed_reg;
            end
        endcase
    end

    // Control and clock state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg        <= bcdclk_pkg::TPS_RESET;
            tick_count_reg <= '0;
            time_reg       <= '0;
            alarm_reg      <= '0;
            valid_reg      <= 1'b0;
            armed_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                tps_reg <= cfg_wr_data;
            end
            if (accept) begin
                tick_count_reg <= tick_count_next;
                time_reg       <= time_next;
                alarm_reg      <= alarm_next;
                valid_reg      <= valid_next;
                armed_reg      <= armed_next;
                m_tvalid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg   <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {1'b0, event_hit, armed_next, valid_next, time_next};
        end
    end

endmodule

### hdl/bcd_clock_with_alarm_chk.sv
// Port-level checker for the BCD clock with alarm, bound to the top level.
// Depends on bcdclk_pkg and bcd_clock_with_alarm_top_macros.svh.
`include "bcd_clock_with_alarm_top_macros.svh"

module bcd_clock_with_alarm_chk (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [bcdclk_pkg::S_DATA_W-1:0] s_tdata,
    input logic [bcdclk_pkg::S_USER_W-1:0] s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [bcdclk_pkg::M_DATA_W-1:0] m_tdata
);

    logic                          set_item;
    logic                          set_shown;
    logic                          stalled;
    logic                          event_item;
    logic                          at_minute;
    logic [bcdclk_pkg::TIME_W-1:0] in_time;
    logic [bcdclk_pkg::TIME_W-1:0] out_time;

    assign set_item   = s_tvalid && s_tready
                        && s_tuser == bcdclk_pkg::MODE_SET_TIME;
    assign set_shown  = m_tvalid && m_tdata[bcdclk_pkg::VALID_BIT];
    assign stalled    = m_tvalid && !m_tready;
    assign event_item = m_tvalid && m_tdata[bcdclk_pkg::EVENT_BIT];
    assign at_minute  = m_tdata[bcdclk_pkg::ARMED_BIT]
                        && m_tdata[bcdclk_pkg::SU_LSB+3:bcdclk_pkg::ST_LSB] == '0;
    assign in_time    = s_tdata[bcdclk_pkg::TIME_W-1:0];
    assign out_time   = m_tdata[bcdclk_pkg::TIME_W-1:0];

    // nothing is offered right after reset
    `BCLK_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "m_tvalid after reset")

    // a stalled item stays put
    `BCLK_ASSERT(a_stall_hold, stalled |=> m_tvalid && $stable(m_tdata), "stalled item changed")

    // an alarm fires only armed and on a full minute
    `BCLK_ASSERT(a_event_minute, event_item |-> at_minute, "alarm event off minute")

    // a set-time item shows the loaded digits, marked valid, in the next result
    `BCLK_ASSERT(a_set_time, set_item |=> set_shown && out_time == $past(in_time), "set time lost")

endmodule

bind bcd_clock_with_alarm_top bcd_clock_with_alarm_chk u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### verif/testbench.sv
// Self-checking testbench for the 24-hour BCD clock with alarm.
// Depends on bcdclk_pkg and bcd_clock_with_alarm_top; predicts every result
// item with its own clock model and checks each one field by field.
module testbench;
    import bcdclk_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    // Result fields in m_tdata order, bit 23 left out
    typedef struct packed {
        logic        alarm_hit;
        logic        armed;
        logic        valid;
        clock_time_t now;
    } readout_t;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [TPS_W-1:0]    cfg_wr_data = '0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata     = '0;
    logic [S_USER_W-1:0] s_tuser     = '0;
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // Clock model state
    logic [TPS_W-1:0] model_tps;
    logic [TPS_W-1:0] model_ticks;
    clock_time_t      model_time;
    clock_time_t      model_alarm;
    logic             model_valid;
    logic             model_armed;

    readout_t expected_readouts[$];

    int src_idle_pct = 0;
    int rx_stall_pct = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int alarm_hits   = 0;
    int err_count    = 0;
    int cycles       = 0;

    bcd_clock_with_alarm_top u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // 20-unit clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // One-second increment; a carry ripples up while the digit is at its top
    function automatic clock_time_t next_second(input clock_time_t t);
        clock_time_t n;
        logic        carry;
        n = t;
        carry = 1'b1;
        if (t.second_units >= 4'd9) begin
            n.second_units = '0;
        end else begin
            n.second_units = t.second_units + 4'd1;
            carry = 1'b0;
        end
        if (carry) begin
            if (t.second_tens >= 3'd5) begin
                n.second_tens = '0;
            end else begin
                n.second_tens = t.second_tens + 3'd1;
                carry = 1'b0;
            end
        end
        if (carry) begin
            if (t.minute_units >= 4'd9) begin
                n.minute_units = '0;
            end else begin
                n.minute_units = t.minute_units + 4'd1;
                carry = 1'b0;
            end
        end
        if (carry) begin
            if (t.minute_tens >= 3'd5) begin
                n.minute_tens = '0;
            end else begin
                n.minute_tens = t.minute_tens + 3'd1;
                carry = 1'b0;
            end
        end
        // hours: 23, or any hour_tens of 2 or more with hour_units of 3 or more, wraps to 00
        if (carry) begin
            if (t.hour_tens >= 2'd2 && t.hour_units >= 4'd3) begin
                n.hour_tens  = '0;
                n.hour_units = '0;
            end else if (t.hour_units >= 4'd9) begin
                n.hour_units = '0;
                n.hour_tens  = t.hour_tens + 2'd1;
            end else begin
                n.hour_units = t.hour_units + 4'd1;
            end
        end
        return n;
    endfunction

    // Apply one accepted item to the model and queue the readout it causes
    task automatic clock_model_step(input mode_t mode, input clock_time_t digits);
        readout_t    r;
        logic [16:0] ticks_next;
        r.alarm_hit = 1'b0;
        case (mode)
            MODE_TICK: begin
                ticks_next = {1'b0, model_ticks} + 17'd1;
                if (ticks_next >= {1'b0, model_tps}) begin
                    model_ticks = '0;
                    model_time  = next_second(model_time);
                    r.alarm_hit = model_armed && model_time == model_alarm
                                  && model_time.second_tens == 3'd0
                                  && model_time.second_units == 4'd0;
                end else begin
                    model_ticks = ticks_next[TPS_W-1:0];
                end
            end
            MODE_SET_TIME: begin
                model_time  = digits;
                model_valid = 1'b1;
            end
            MODE_SET_ALARM: begin
                model_alarm = digits;
                model_armed = 1'b1;
            end
            default: begin
                model_armed = !model_armed;
            end
        endcase
        r.now   = model_time;
        r.valid = model_valid;
        r.armed = model_armed;
        expected_readouts.push_back(r);
    endtask

    task automatic report_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
            err_count++;
        end
    endtask

    // Result checker: the handshake seen at the falling edge completes at the next rise
    always @(negedge aclk) begin
        readout_t got;
        readout_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[22:0];
            results_seen++;
            if (expected_readouts.size() == 0) begin
                $display("%0t: unexpected result item, got %h", $time, m_tdata);
                err_count++;
            end else begin
                exp_r = expected_readouts.pop_front();
                if (exp_r.alarm_hit) alarm_hits++;
                report_field("now_hour_tens",    exp_r.now.hour_tens,    got.now.hour_tens);
                report_field("now_hour_units",   exp_r.now.hour_units,   got.now.hour_units);
                report_field("now_minute_tens",  exp_r.now.minute_tens,  got.now.minute_tens);
                report_field("now_minute_units", exp_r.now.minute_units, got.now.minute_units);
                report_field("now_second_tens",  exp_r.now.second_tens,  got.now.second_tens);
                report_field("now_second_units", exp_r.now.second_units, got.now.second_units);
                report_field("time_valid",       exp_r.valid,            got.valid);
                report_field("alarm_enabled",    exp_r.armed,            got.armed);
                report_field("alarm_event",      exp_r.alarm_hit,        got.alarm_hit);
            end
        end
    end

    // Send one item, with an optional idle gap first; returns right after acceptance
    task automatic send_item(input mode_t mode, input clock_time_t digits);
        int   gap;
        logic taken;
        gap = 0;
        if ($urandom_range(99) < src_idle_pct) gap = $urandom_range(1, 4);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'b0, digits};
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
        clock_model_step(mode, digits);
        items_sent++;
    endtask

    // Stop sending until every queued readout has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (expected_readouts.size() != 0);
    endtask

    task automatic write_ticks_per_second(input logic [TPS_W-1:0] value);
        wait_drained();
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        model_tps = value;
    endtask

    function automatic clock_time_t make_time(input int h, input int m, input int s);
        clock_time_t t;
        t.hour_tens    = 2'(h / 10);
        t.hour_units   = 4'(h % 10);
        t.minute_tens  = 3'(m / 10);
        t.minute_units = 4'(m % 10);
        t.second_tens  = 3'(s / 10);
        t.second_units = 4'(s % 10);
        return t;
    endfunction

    function automatic clock_time_t noise_digits();
        logic [19:0] bits;
        bits = 20'($urandom());
        return bits;
    endfunction

    function automatic clock_time_t legal_time();
        int h;
        h = $urandom_range(0, 23);
        return make_time(h, $urandom_range(0, 59), $urandom_range(0, 59));
    endfunction

    // Reset values, prescaler counting at 1000, alarm enable toggling
    task automatic test_reset_state();
        send_item(MODE_TICK, noise_digits());
        send_item(MODE_TICK, make_time(0, 0, 0));
        send_item(MODE_TOGGLE, noise_digits());
        send_item(MODE_TOGGLE, '1);
    endtask

    // Carries through every digit, hour units into tens, 23:59:59 to midnight
    task automatic test_rollovers();
        write_ticks_per_second(16'd1);
        send_item(MODE_SET_TIME, make_time(23, 59, 59));
        send_item(MODE_TICK, '1);
        send_item(MODE_SET_TIME, make_time(9, 59, 59));
        send_item(MODE_TICK, '0);
        send_item(MODE_SET_TIME, make_time(19, 59, 59));
        send_item(MODE_TICK, noise_digits());
    endtask

    // Alarm fires on a matching :00, not when disarmed
    task automatic test_alarm_match();
        send_item(MODE_SET_ALARM, make_time(0, 1, 0));
        send_item(MODE_SET_TIME, make_time(0, 0, 59));
        send_item(MODE_TICK, '0);
        send_item(MODE_TOGGLE, '0);
        send_item(MODE_SET_TIME, make_time(0, 0, 59));
        send_item(MODE_TICK, '0);
        send_item(MODE_TOGGLE, '0);
    endtask

    // Digits loaded out of range wrap at the compare thresholds
    task automatic test_odd_digits();
        send_item(MODE_SET_TIME, '1);
        send_item(MODE_TICK, '0);
        send_item(MODE_SET_TIME, {4'd9, 3'd5, 4'd9, 3'd5, 4'd2, 2'd3});
        send_item(MODE_TICK, '0);
        send_item(MODE_SET_TIME, {4'd9, 3'd5, 4'd9, 3'd5, 4'd12, 2'd1});
        send_item(MODE_TICK, '0);
        send_item(MODE_SET_ALARM, '1);
    endtask

    // Zero behaves as one; lowering below the current count completes a second
    task automatic test_prescaler_edges();
        write_ticks_per_second(16'd0);
        send_item(MODE_TICK, '0);
        write_ticks_per_second(16'hFFFF);
        repeat (5) send_item(MODE_TICK, noise_digits());
        write_ticks_per_second(16'd3);
        send_item(MODE_TICK, '0);
    endtask

    // Set a time just before a minute boundary, arm the alarm on it and tick through
    task automatic alarm_approach();
        clock_time_t start_t;
        clock_time_t target;
        int          secs_left;
        int          n_ticks;
        start_t = legal_time();
        if ($urandom_range(3) == 0) start_t = make_time(23, 59, 0);
        start_t.second_tens  = 3'd5;
        start_t.second_units = 4'($urandom_range(0, 9));
        secs_left = 10 - start_t.second_units;
        target = start_t;
        repeat (secs_left) target = next_second(target);
        // near miss on one digit now and then
        if ($urandom_range(9) < 2) target.minute_units = target.minute_units ^ 4'd1;
        send_item(MODE_SET_TIME, start_t);
        send_item(MODE_SET_ALARM, target);
        if ($urandom_range(9) < 2) send_item(MODE_TOGGLE, noise_digits());
        n_ticks = secs_left * model_tps + $urandom_range(0, 2);
        repeat (n_ticks) send_item(MODE_TICK, noise_digits());
    endtask

    // One phase of random traffic at the given idle mix and prescaler setting
    task automatic test_random_traffic(input int src_pct, input int rx_pct,
                                       input logic [TPS_W-1:0] tps, input int n_items);
        int          stop_at;
        int          pick;
        mode_t       mode;
        clock_time_t digits;
        write_ticks_per_second(tps);
        src_idle_pct = src_pct;
        rx_stall_pct = rx_pct;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 20) begin
                alarm_approach();
            end else if (pick < 22) begin
                wait_drained();
            end else begin
                mode = mode_t'($urandom_range(0, 3));
                if ($urandom_range(1) == 0) mode = MODE_TICK;
                digits = noise_digits();
                if ((mode == MODE_SET_TIME || mode == MODE_SET_ALARM)
                    && $urandom_range(3) != 0) begin
                    digits = legal_time();
                end
                send_item(mode, digits);
            end
        end
    endtask

    initial begin
        model_tps   = TPS_RESET;
        model_ticks = '0;
        model_time  = '0;
        model_alarm = '0;
        model_valid = 1'b0;
        model_armed = 1'b0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct = 20;
        rx_stall_pct = 20;
        test_reset_state();
        test_rollovers();
        test_alarm_match();
        test_odd_digits();
        test_prescaler_edges();

        test_random_traffic(0, 0, 16'd1, 160);
        test_random_traffic(55, 0, 16'd2, 160);
        test_random_traffic(0, 55, 16'd1, 160);
        test_random_traffic(20, 20, 16'd4, 160);

        wait_drained();
        repeat (10) @(posedge aclk);

        $display("Sent %0d items, checked %0d results, %0d alarm events seen.",
                 items_sent, results_seen, alarm_hits);
        $display("Covered rollovers, odd digits, prescaler edges and four idle mixes.");
        if (err_count == 0 && expected_readouts.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0t: %0d mismatches, %0d results missing", $time, err_count,
                     expected_readouts.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule
